/* rtl/wavhp_pkg.sv */
// Package for the WAV PCM header parser: status codes, chunk tags, the
// result record and the magic-word lookup. No dependencies.
`timescale 1ns / 1ps

package wavhp_pkg;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_OVERRUN     = 3'd3,
        ST_FMT_SMALL   = 3'd4,
        ST_UNSUPPORTED = 3'd5,
        ST_MISSING     = 3'd6
    } status_t;

    localparam logic [31:0] TAG_RIFF    = 32'h52494646;
    localparam logic [31:0] TAG_WAVE    = 32'h57415645;
    localparam logic [31:0] TAG_FMT     = 32'h666D7420;
    localparam logic [31:0] TAG_DATA    = 32'h64617461;
    localparam logic [31:0] MIN_FILE    = 32'd44;
    localparam logic [31:0] MAGIC_END   = 32'd12;
    localparam logic [15:0] PCM_CODE    = 16'd1;
    localparam logic [15:0] PCM_BITS    = 16'd16;
    localparam int          TDATA_WIDTH = 120;

    typedef struct packed {
        logic [31:0] data_length;
        logic [31:0] data_offset;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        status_t     status;
    } result_t;

    // Expected byte of the twelve-byte file preamble; positions 4 to 7 hold
    // the file size and are not checked.
    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] value;
        case (pos)
            4'd0:    value = TAG_RIFF[31:24];
            4'd1:    value = TAG_RIFF[23:16];
            4'd2:    value = TAG_RIFF[15:8];
            4'd3:    value = TAG_RIFF[7:0];
            4'd8:    value = TAG_WAVE[31:24];
            4'd9:    value = TAG_WAVE[23:16];
            4'd10:   value = TAG_WAVE[15:8];
            4'd11:   value = TAG_WAVE[7:0];
            default: value = 8'd0;
        endcase
        return value;
    endfunction

endpackage

/* rtl/wav_pcm_header_parser.sv */
// Top level of the WAV PCM header parser: stream handshake and result
// register around wavhp_parser. Depends on wavhp_pkg and wavhp_parser.
`timescale 1ns / 1ps

// The block takes a WAV file one byte per word on the slave side, with
// s_tlast on the last byte, and gives one result word per file on the
// master side when that last byte is accepted. It accepts one byte in every
// cycle; s_tready falls only while a finished result waits in the output
// register and m_tready is low, so the result register alone sets the rate.
// The result is registered and appears in the cycle after the last byte is taken. The parser is
// ready for the next file in the cycle after the last byte.
module wav_pcm_header_parser
    import wavhp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [7:0] file_byte
    input  logic                   s_tlast,  // final_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] status, [34:3] sample_rate, [50:35] channel_count,
    // [82:51] data_offset, [114:83] data_length, [119:115] zero
    output logic [TDATA_WIDTH-1:0] m_tdata
);

    logic    accept;
    result_t result;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    wavhp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (accept),
        .file_byte  (s_tdata),
        .final_byte (s_tlast),
        .result     (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept && s_tlast) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_WIDTH - $bits(result_t)){1'b0}}, out_data_reg};

endmodule

/* rtl/wavhp_parser.sv */
// Parser state for the WAV PCM header parser: magic check, chunk walk and
// fmt/data capture, one byte per cycle while byte_en is high. Depends on wavhp_pkg.
`timescale 1ns / 1ps

module wavhp_parser
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  logic [7:0]  file_byte,
    input  logic        final_byte,
    output result_t     result
);

    logic [31:0] pos_reg, pos_next;
    logic        magic_reg, magic_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] len_m1_reg, len_m1_next;
    logic [31:0] cnt_reg, cnt_next;
    logic        in_body_reg, in_body_next;
    logic        done_reg, done_next;
    logic [31:0] start_reg, start_next;
    logic [15:0] code_reg, code_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] chan_reg, chan_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [31:0] doff_reg, doff_next;
    logic [31:0] dlen_reg, dlen_next;
    status_t     err_reg, err_next;

    logic        do_finish;
    logic [31:0] fin_len;
    logic [31:0] fin_start;
    logic        end_body;
    status_t     err_final;
    status_t     status;

    always_comb begin
        pos_next      = pos_reg;
        magic_next    = magic_reg;
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        len_m1_next   = len_m1_reg;
        cnt_next      = cnt_reg;
        in_body_next  = in_body_reg;
        done_next     = done_reg;
        start_next    = start_reg;
        code_next     = code_reg;
        bits_next     = bits_reg;
        rate_next     = rate_reg;
        chan_next     = chan_reg;
        fmt_seen_next = fmt_seen_reg;
        doff_next     = doff_reg;
        dlen_next     = dlen_reg;
        err_next      = err_reg;
        do_finish     = 1'b0;
        fin_len       = len_reg;
        fin_start     = start_reg;
        end_body      = 1'b0;

        if (byte_en) begin
            pos_next = (&pos_reg) ? pos_reg : pos_reg + 32'd1;
            if (pos_reg < MAGIC_END) begin
                if ((pos_reg[3:0] < 4'd4 || pos_reg[3:0] >= 4'd8)
                        && file_byte != magic_byte(pos_reg[3:0])) begin
                    magic_next = 1'b0;
                end
            end else if (err_reg == ST_OK) begin
                if (!in_body_reg) begin
                    if (phase_reg < 3'd4) begin
                        tag_next = (phase_reg == 3'd0) ? {24'd0, file_byte}
                                                       : {tag_reg[23:0], file_byte};
                    end else begin
                        len_next = ((phase_reg == 3'd4) ? 32'd0 : len_reg)
                                 | ({24'd0, file_byte} << {phase_reg[1:0], 3'b000});
                    end
                    phase_next = phase_reg + 3'd1;
                    if (phase_reg == 3'd7) begin
                        start_next   = pos_next;
                        len_m1_next  = len_next - 32'd1;
                        cnt_next     = 32'd0;
                        done_next    = 1'b0;
                        fin_len      = len_next;
                        fin_start    = pos_next;
                        if (len_next == 32'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            in_body_next = 1'b1;
                        end
                    end
                end else begin
                    if (tag_reg == TAG_FMT && cnt_reg[31:4] == 28'd0) begin
                        case (cnt_reg[3:0])
                            4'd0:    code_next[7:0]   = file_byte;
                            4'd1:    code_next[15:8]  = file_byte;
                            4'd2:    chan_next[7:0]   = file_byte;
                            4'd3:    chan_next[15:8]  = file_byte;
                            4'd4:    rate_next[7:0]   = file_byte;
                            4'd5:    rate_next[15:8]  = file_byte;
                            4'd6:    rate_next[23:16] = file_byte;
                            4'd7:    rate_next[31:24] = file_byte;
                            4'd14:   bits_next[7:0]   = file_byte;
                            4'd15:   bits_next[15:8]  = file_byte;
                            default: ;
                        endcase
                    end
                    cnt_next = cnt_reg + 32'd1;
                    if (cnt_reg == len_m1_reg) begin
                        do_finish = 1'b1;
                        done_next = 1'b1;
                    end
                    end_body = len_reg[0] ? (cnt_reg == len_reg) : (cnt_reg == len_m1_reg);
                    if (end_body) begin
                        in_body_next = 1'b0;
                    end
                end
            end
        end

        if (do_finish) begin
            if (tag_reg == TAG_FMT) begin
                if (fin_len[31:4] == 28'd0) begin
                    err_next = ST_FMT_SMALL;
                end else if (code_next != PCM_CODE || bits_next != PCM_BITS
                        || chan_next == 16'd0) begin
                    err_next = ST_UNSUPPORTED;
                end else begin
                    fmt_seen_next = 1'b1;
                end
            end else if (tag_reg == TAG_DATA) begin
                doff_next = fin_start;
                dlen_next = fin_len;
            end
        end

        err_final = err_next;
        if (err_next == ST_OK && in_body_next && !done_next) begin
            err_final = ST_OVERRUN;
        end

        if (pos_next < MIN_FILE) begin
            status = ST_TOO_SHORT;
        end else if (!magic_next) begin
            status = ST_BAD_MAGIC;
        end else if (err_final != ST_OK) begin
            status = err_final;
        end else if (!fmt_seen_next || dlen_next == 32'd0) begin
            status = ST_MISSING;
        end else begin
            status = ST_OK;
        end

        result.status = status;
        if (status == ST_OK) begin
            result.sample_rate   = rate_next;
            result.channel_count = chan_next;
            result.data_offset   = doff_next;
            result.data_length   = dlen_next;
        end else begin
            result.sample_rate   = 32'd0;
            result.channel_count = 16'd0;
            result.data_offset   = 32'd0;
            result.data_length   = 32'd0;
        end
    end

    // The final byte of a file returns the control state to reset for the next file.
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_en && final_byte)) begin
            pos_reg      <= 32'd0;
            magic_reg    <= 1'b1;
            phase_reg    <= 3'd0;
            in_body_reg  <= 1'b0;
            done_reg     <= 1'b0;
            fmt_seen_reg <= 1'b0;
            dlen_reg     <= 32'd0;
            err_reg      <= ST_OK;
        end else begin
            pos_reg      <= pos_next;
            magic_reg    <= magic_next;
            phase_reg    <= phase_next;
            in_body_reg  <= in_body_next;
            done_reg     <= done_next;
            fmt_seen_reg <= fmt_seen_next;
            dlen_reg     <= dlen_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg    <= tag_next;
        len_reg    <= len_next;
        len_m1_reg <= len_m1_next;
        cnt_reg    <= cnt_next;
        start_reg  <= start_next;
        code_reg   <= code_next;
        bits_reg   <= bits_next;
        rate_reg   <= rate_next;
        chan_reg   <= chan_next;
        doff_reg   <= doff_next;
    end

endmodule

/* rtl/wavhp_checker.sv */
// Port-level checks for the WAV PCM header parser, bound to the top level.
// Depends on wavhp_pkg and wav_pcm_header_parser.
`timescale 1ns / 1ps

module wavhp_checker
    import wavhp_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [7:0]             s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_WIDTH-1:0] m_tdata
);

    logic in_accept;
    assign in_accept = s_tvalid && s_tready && (s_tdata == s_tdata);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid && !m_tready) |-> $past(in_accept && s_tlast))
        else $error("result word without a last byte");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[114:3] == '0)
        else $error("failing status with nonzero fields");

    a_ok_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ST_OK |-> m_tdata[114:83] != 32'd0)
        else $error("ok status with empty data chunk");

endmodule

bind wav_pcm_header_parser wavhp_checker u_wavhp_checker (.*);
